/* src/lzsd_pkg.sv */
`timescale 1ns / 1ps

package lzsd_pkg;

   // window geometry
   localparam int MAX_WINDOW = 4096;
   localparam int MAX_MATCH  = 18;
   localparam int WIN_AW     = $clog2(MAX_WINDOW);
   localparam int FILL_W     = WIN_AW + 1;
   localparam int WIN_LG_MIN = 5;
   localparam logic [3:0] WIN_LOG2_RESET = 4'd12;

   // token fields
   localparam int OFFSET_W = 12;
   localparam int LEN_W    = 4;
   localparam int REM_W    = 5;
   localparam int COUNT_W  = 24;
   localparam int CSR_W    = 24;

   // queue sizes
   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
   localparam int RSPQ_DEPTH = 4;
   localparam int RSPQ_AW    = $clog2(RSPQ_DEPTH);

   localparam logic [7:0] SPACE_CHAR  = 8'h20;
   localparam logic [7:0] INVERT_MASK = 8'hFF;
   localparam logic [COUNT_W-1:0] OUT_LIMIT_RESET = '1;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_INVERT    = 2'd0,
      CSR_WIN_LOG2  = 2'd1,
      CSR_OUT_LIMIT = 2'd2
   } csr_index_type;

   // token parser phase
   typedef enum logic [2:0] {
      PH_FLAG  = 3'b001,
      PH_TOKEN = 3'b010,
      PH_HIGH  = 3'b100
   } phase_type;

   // command from the parser to the executor
   typedef enum logic [1:0] {
      CMD_NOP   = 2'd0,
      CMD_LIT   = 2'd1,
      CMD_MATCH = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic [OFFSET_W-1:0]   offset;   // literal byte sits in the low 8 bits
      logic [LEN_W-1:0]      len;
      logic                  last;
   } cmd_type;

   // one byte operation inside the executor
   typedef enum logic [1:0] {
      OP_LIT   = 2'd0,
      OP_READ  = 2'd1,
      OP_FINAL = 2'd2
   } op_kind_type;

   typedef struct packed {
      logic                valid;
      op_kind_type         kind;
      logic [7:0]          data;
      logic [WIN_AW-1:0]   addr;
      logic                run_end;
      logic                cmd_last;
   } op_type;

   typedef struct packed {
      logic [7:0]          out_byte;
      logic                run_last;
      logic                is_status;
      logic                overflow_error;
      logic [COUNT_W-1:0]  byte_count;
   } rsp_type;

   // executor issue state
   typedef enum logic [2:0] {
      IS_IDLE  = 3'b001,
      IS_MATCH = 3'b010,
      IS_FINAL = 3'b100
   } issue_state_type;

   // address mask of the window in use, log2 clamped to the legal range
   function automatic logic [WIN_AW-1:0] win_mask(input logic [3:0] lg);
      logic [3:0]      c;
      logic [WIN_AW:0] n;
      c = lg;
      if (c < 4'(WIN_LG_MIN)) c = 4'(WIN_LG_MIN);
      if (c > 4'(WIN_AW)) c = 4'(WIN_AW);
      n = (WIN_AW + 1)'(1) << c;
      return WIN_AW'(n - 1'b1);
   endfunction

   // first write position of a stream: window size minus the longest match
   function automatic logic [WIN_AW-1:0] win_start(input logic [WIN_AW-1:0] mask);
      return mask - WIN_AW'(MAX_MATCH - 1);
   endfunction

endpackage

/* src/lzsd_front.sv */
`timescale 1ns / 1ps

module lzsd_front import lzsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       init,
   input  logic       invert,
   input  logic       push,
   input  logic [7:0] in_byte,
   input  logic       last_in,
   input  logic       cmd_full,
   output logic       full,
   output logic       cmd_push,
   output cmd_type    cmd
);

   phase_type  phase_ff, phase_in;
   logic [7:0] flag_bits_ff, flag_bits_in;
   logic [3:0] flags_left_ff, flags_left_in;
   logic [7:0] offset_low_ff, offset_low_in;

   logic       accept;
   logic [7:0] b;
   logic [3:0] left_dec;

   assign full     = cmd_full;
   assign accept   = push & ~cmd_full;
   assign b        = in_byte ^ (invert ? INVERT_MASK : 8'h00);
   assign left_dec = flags_left_ff - 4'd1;

   // parse one request byte into at most one command
   always_comb begin
      phase_in      = phase_ff;
      flag_bits_in  = flag_bits_ff;
      flags_left_in = flags_left_ff;
      offset_low_in = offset_low_ff;
      cmd_push      = 1'b0;
      cmd.kind      = CMD_NOP;
      cmd.offset    = '0;
      cmd.len       = '0;
      cmd.last      = last_in;
      if (accept) begin
         case (phase_ff)
            PH_FLAG: begin
               flag_bits_in  = b;
               flags_left_in = 4'd8;
               phase_in      = PH_TOKEN;
            end
            PH_TOKEN: begin
               if (flag_bits_ff[0]) begin
                  cmd_push      = 1'b1;
                  cmd.kind      = CMD_LIT;
                  cmd.offset    = {{(OFFSET_W - 8){1'b0}}, b};
                  flag_bits_in  = flag_bits_ff >> 1;
                  flags_left_in = left_dec;
                  phase_in      = (left_dec == 4'd0) ? PH_FLAG : PH_TOKEN;
               end else begin
                  offset_low_in = b;
                  phase_in      = PH_HIGH;
               end
            end
            PH_HIGH: begin
               cmd_push      = 1'b1;
               cmd.kind      = CMD_MATCH;
               cmd.offset    = {b[7:4], offset_low_ff};
               cmd.len       = b[3:0];
               flag_bits_in  = flag_bits_ff >> 1;
               flags_left_in = left_dec;
               phase_in      = (left_dec == 4'd0) ? PH_FLAG : PH_TOKEN;
            end
            default: begin
               phase_in = PH_FLAG;
            end
         endcase
         // end of stream: always hand a command over, drop any partial token
         if (last_in) begin
            cmd_push      = 1'b1;
            phase_in      = PH_FLAG;
            flag_bits_in  = '0;
            flags_left_in = '0;
            offset_low_in = '0;
         end
      end
      if (init) begin
         phase_in      = PH_FLAG;
         flag_bits_in  = '0;
         flags_left_in = '0;
         offset_low_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_FLAG;
         flag_bits_ff  <= '0;
         flags_left_ff <= '0;
         offset_low_ff <= '0;
      end else begin
         phase_ff      <= phase_in;
         flag_bits_ff  <= flag_bits_in;
         flags_left_ff <= flags_left_in;
         offset_low_ff <= offset_low_in;
      end
   end

endmodule

/* src/lzsd_cmd_queue.sv */
`timescale 1ns / 1ps

module lzsd_cmd_queue import lzsd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  cmd_type wr_data,
   input  logic    rd_en,
   output cmd_type rd_data,
   output logic    full,
   output logic    empty
);

   cmd_type            entry_ff [CMDQ_DEPTH];
   logic [CMDQ_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_AW:0]   count_ff, count_in;
   logic               do_wr, do_rd;

   assign full    = (count_ff == (CMDQ_AW + 1)'(CMDQ_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en & ~full;
   assign do_rd   = rd_en & ~empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) count_in = count_ff + 1'b1;
      if (!do_wr && do_rd) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) entry_ff[wr_ptr_ff] <= wr_data;
   end

endmodule

/* src/lzsd_back.sv */
`timescale 1ns / 1ps

module lzsd_back import lzsd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               init,
   input  logic [WIN_AW-1:0]  init_start,
   input  logic [WIN_AW-1:0]  mask,
   input  logic [COUNT_W-1:0] out_limit,
   input  logic               cmd_empty,
   input  cmd_type            cmd,
   output logic               cmd_pop,
   input  logic               rsp_pop,
   output logic               rsp_empty,
   output rsp_type            rsp
);

   // issue stage
   issue_state_type   is_ff, is_in;
   logic [WIN_AW-1:0] rd_addr_ff, rd_addr_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic              cur_last_ff, cur_last_in;
   op_type            op_in, op_ff;
   logic              room;
   logic [RSPQ_AW+1:0] pending;
   logic [WIN_AW-1:0] start_addr;

   // commit stage
   logic [7:0]         mem [MAX_WINDOW];
   logic [7:0]         mem_q_ff;
   logic [WIN_AW-1:0]  wp_ff, wp_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               error_ff, error_in;
   logic               lw_valid_ff;
   logic [WIN_AW-1:0]  lw_addr_ff;
   logic [7:0]         lw_data_ff;
   logic [WIN_AW-1:0]  rel;
   logic [FILL_W-1:0]  win_n;
   logic               stored;
   logic [7:0]         rd_byte, byte_val;
   logic               wr_en;
   logic               rq_push;
   rsp_type            rq_data;

   // result queue
   rsp_type            rq_ff [RSPQ_DEPTH];
   logic [RSPQ_AW-1:0] rq_wr_ff, rq_rd_ff;
   logic [RSPQ_AW:0]   rq_count_ff, rq_count_in;
   logic               rq_pop;

   // an op is issued only when the result queue can take its result
   assign pending    = {1'b0, rq_count_ff} + {{(RSPQ_AW + 1){1'b0}}, op_ff.valid};
   assign room       = (pending < (RSPQ_AW + 2)'(RSPQ_DEPTH));
   assign start_addr = cmd.offset[WIN_AW-1:0] & mask;

   // issue sequencer: one op per cycle while the result queue has room, match bytes walk the window
   always_comb begin
      is_in       = is_ff;
      rd_addr_in  = rd_addr_ff;
      rem_in      = rem_ff;
      cur_last_in = cur_last_ff;
      cmd_pop     = 1'b0;
      op_in       = '0;
      if (room) begin
         case (is_ff)
            IS_IDLE: begin
               if (!cmd_empty) begin
                  cmd_pop        = 1'b1;
                  cur_last_in    = cmd.last;
                  op_in.cmd_last = cmd.last;
                  op_in.run_end  = 1'b1;
                  case (cmd.kind)
                     CMD_LIT: begin
                        op_in.valid = 1'b1;
                        op_in.kind  = OP_LIT;
                        op_in.data  = cmd.offset[7:0];
                        if (cmd.last) is_in = IS_FINAL;
                     end
                     CMD_MATCH: begin
                        op_in.valid   = 1'b1;
                        op_in.kind    = OP_READ;
                        op_in.addr    = start_addr;
                        op_in.run_end = 1'b0;
                        rd_addr_in    = (start_addr + 1'b1) & mask;
                        rem_in        = {1'b0, cmd.len} + REM_W'(2);
                        is_in         = IS_MATCH;
                     end
                     CMD_NOP: begin
                        op_in.valid = cmd.last;
                        op_in.kind  = OP_FINAL;
                     end
                     default: begin
                        op_in.valid = 1'b0;
                     end
                  endcase
               end
            end
            IS_MATCH: begin
               op_in.valid    = 1'b1;
               op_in.kind     = OP_READ;
               op_in.addr     = rd_addr_ff;
               op_in.cmd_last = cur_last_ff;
               op_in.run_end  = (rem_ff == REM_W'(1));
               rd_addr_in     = (rd_addr_ff + 1'b1) & mask;
               rem_in         = rem_ff - 1'b1;
               if (rem_ff == REM_W'(1)) is_in = cur_last_ff ? IS_FINAL : IS_IDLE;
            end
            IS_FINAL: begin
               op_in.valid    = 1'b1;
               op_in.kind     = OP_FINAL;
               op_in.cmd_last = 1'b1;
               op_in.run_end  = 1'b1;
               is_in          = IS_IDLE;
            end
            default: begin
               is_in = IS_IDLE;
            end
         endcase
      end
   end

   // op register: only the state and the valid bit are reset
   always_ff @(posedge clock) begin
      rd_addr_ff     <= rd_addr_in;
      rem_ff         <= rem_in;
      cur_last_ff    <= cur_last_in;
      op_ff.kind     <= op_in.kind;
      op_ff.data     <= op_in.data;
      op_ff.addr     <= op_in.addr;
      op_ff.run_end  <= op_in.run_end;
      op_ff.cmd_last <= op_in.cmd_last;
      if (reset) begin
         is_ff       <= IS_IDLE;
         op_ff.valid <= 1'b0;
      end else begin
         is_ff       <= is_in;
         op_ff.valid <= op_in.valid;
      end
   end

   // window RAM: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wp_ff] <= byte_val;
      mem_q_ff <= mem[op_in.addr];
   end

   // entries past the fill count read as spaces; bypass a same-cycle write
   assign win_n   = {1'b0, mask} + 1'b1;
   assign rel     = (op_ff.addr - win_start(mask)) & mask;
   assign stored  = ({1'b0, rel} < fill_ff);
   assign rd_byte = (lw_valid_ff && lw_addr_ff == op_ff.addr) ? lw_data_ff :
                    (stored ? mem_q_ff : SPACE_CHAR);
   assign byte_val = (op_ff.kind == OP_READ) ? rd_byte : op_ff.data;

   // commit: limit check, result, window write
   always_comb begin
      wp_in    = wp_ff;
      fill_in  = fill_ff;
      count_in = count_ff;
      error_in = error_ff;
      wr_en    = 1'b0;
      rq_push  = 1'b0;
      rq_data  = '0;
      if (op_ff.valid) begin
         case (op_ff.kind)
            OP_FINAL: begin
               rq_push                = 1'b1;
               rq_data.run_last       = 1'b1;
               rq_data.is_status      = 1'b1;
               rq_data.overflow_error = error_ff;
               rq_data.byte_count     = count_ff;
               wp_in    = win_start(mask);
               fill_in  = '0;
               count_in = '0;
               error_in = 1'b0;
            end
            OP_LIT, OP_READ: begin
               if (!error_ff) begin
                  rq_push = 1'b1;
                  if (count_ff >= out_limit) begin
                     error_in               = 1'b1;
                     rq_data.run_last       = ~op_ff.cmd_last;
                     rq_data.is_status      = 1'b1;
                     rq_data.overflow_error = 1'b1;
                     rq_data.byte_count     = count_ff;
                  end else begin
                     count_in           = count_ff + 1'b1;
                     rq_data.out_byte   = byte_val;
                     rq_data.run_last   = op_ff.run_end & ~op_ff.cmd_last;
                     rq_data.byte_count = count_ff + 1'b1;
                     wr_en              = 1'b1;
                     wp_in              = (wp_ff + 1'b1) & mask;
                     if (fill_ff != win_n) fill_in = fill_ff + 1'b1;
                  end
               end
            end
            default: begin
               rq_push = 1'b0;
            end
         endcase
      end
      if (init) begin
         wp_in    = init_start;
         fill_in  = '0;
         count_in = '0;
         error_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= win_start(win_mask(WIN_LOG2_RESET));
         fill_ff     <= '0;
         count_ff    <= '0;
         error_ff    <= 1'b0;
         lw_valid_ff <= 1'b0;
      end else begin
         wp_ff       <= wp_in;
         fill_ff     <= fill_in;
         count_ff    <= count_in;
         error_ff    <= error_in;
         lw_valid_ff <= wr_en & ~init;
      end
   end

   always_ff @(posedge clock) begin
      lw_addr_ff <= wp_ff;
      lw_data_ff <= byte_val;
   end

   // result queue
   assign rsp_empty = (rq_count_ff == '0);
   assign rq_pop    = rsp_pop & ~rsp_empty;
   assign rsp       = rq_ff[rq_rd_ff];

   always_comb begin
      rq_count_in = rq_count_ff;
      if (rq_push && !rq_pop) rq_count_in = rq_count_ff + 1'b1;
      if (!rq_push && rq_pop) rq_count_in = rq_count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff    <= '0;
         rq_rd_ff    <= '0;
         rq_count_ff <= '0;
      end else begin
         if (rq_push) rq_wr_ff <= rq_wr_ff + 1'b1;
         if (rq_pop) rq_rd_ff <= rq_rd_ff + 1'b1;
         rq_count_ff <= rq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rq_push) rq_ff[rq_wr_ff] <= rq_data;
   end

endmodule

/* src/lzss_stream_decoder_core.sv */
`timescale 1ns / 1ps

// channel   | ports                                        | transfer when
// ----------+----------------------------------------------+----------------------
// request   | push, full, req_in_byte, req_last_in         | push && !full
// response  | pop, empty, rsp_out_byte, rsp_run_last,      | pop && !empty
//           | rsp_is_status, rsp_overflow_error,           |
//           | rsp_byte_count                               |
// config    | csr_valid, csr_ready, csr_index, csr_wdata   | csr_valid && csr_ready
//
// The parser takes one request per cycle into a 4-entry command queue while
// that queue is not full. The executor issues one byte per cycle while the
// response queue has room: one for a literal, 3 to 18 for a match read through
// the single read port of the window RAM, plus the end-of-stream status.
// Reset is synchronous; the window needs no clearing pass, a fill count makes
// unwritten entries read as spaces, so the block is ready right after reset.
// A full response queue stalls the executor, which backs up into full.

module lzss_stream_decoder_core import lzsd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // request
   input  logic               push,
   output logic               full,
   input  logic [7:0]         req_in_byte,
   input  logic               req_last_in,
   // response
   output logic               empty,
   input  logic               pop,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_run_last,
   output logic               rsp_is_status,
   output logic               rsp_overflow_error,
   output logic [COUNT_W-1:0] rsp_byte_count,
   // configuration
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [CSR_W-1:0]   csr_wdata
);

   logic               invert_ff, invert_in;
   logic [3:0]         win_log2_ff, win_log2_in;
   logic [COUNT_W-1:0] out_limit_ff, out_limit_in;
   logic               csr_wr, init;
   logic [WIN_AW-1:0]  mask, init_start;

   logic    cmd_push, cmd_pop, cmd_full, cmd_empty;
   cmd_type cmd_wr, cmd_head;
   rsp_type rsp;

   // configuration registers
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid & csr_ready;
   assign init      = csr_wr && (csr_index == CSR_WIN_LOG2);

   always_comb begin
      invert_in    = invert_ff;
      win_log2_in  = win_log2_ff;
      out_limit_in = out_limit_ff;
      if (csr_wr) begin
         case (csr_index)
            CSR_INVERT:    invert_in    = csr_wdata[0];
            CSR_WIN_LOG2:  win_log2_in  = csr_wdata[3:0];
            CSR_OUT_LIMIT: out_limit_in = csr_wdata[COUNT_W-1:0];
            default:       invert_in    = invert_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         invert_ff    <= 1'b0;
         win_log2_ff  <= WIN_LOG2_RESET;
         out_limit_ff <= OUT_LIMIT_RESET;
      end else begin
         invert_ff    <= invert_in;
         win_log2_ff  <= win_log2_in;
         out_limit_ff <= out_limit_in;
      end
   end

   assign mask       = win_mask(win_log2_ff);
   assign init_start = win_start(win_mask(csr_wdata[3:0]));

   lzsd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .init     (init),
      .invert   (invert_ff),
      .push     (push),
      .in_byte  (req_in_byte),
      .last_in  (req_last_in),
      .cmd_full (cmd_full),
      .full     (full),
      .cmd_push (cmd_push),
      .cmd      (cmd_wr)
   );

   lzsd_cmd_queue u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_push),
      .wr_data (cmd_wr),
      .rd_en   (cmd_pop),
      .rd_data (cmd_head),
      .full    (cmd_full),
      .empty   (cmd_empty)
   );

   lzsd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .init       (init),
      .init_start (init_start),
      .mask       (mask),
      .out_limit  (out_limit_ff),
      .cmd_empty  (cmd_empty),
      .cmd        (cmd_head),
      .cmd_pop    (cmd_pop),
      .rsp_pop    (pop),
      .rsp_empty  (empty),
      .rsp        (rsp)
   );

   assign rsp_out_byte       = rsp.out_byte;
   assign rsp_run_last       = rsp.run_last;
   assign rsp_is_status      = rsp.is_status;
   assign rsp_overflow_error = rsp.overflow_error;
   assign rsp_byte_count     = rsp.byte_count;

`ifndef SYNTH
   // nothing waits in the response queue right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("response queue not empty after reset");

   // an error-free end-of-stream status always closes its request
   a_final_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_is_status && !rsp_overflow_error) |-> rsp_run_last)
      else $error("end-of-stream status without run_last");

   // a data byte never carries an error and always counts itself
   a_data_count: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_is_status) |-> (!rsp_overflow_error && rsp_byte_count != '0))
      else $error("data result with bad count or error flag");
`endif

endmodule
